// ===== rtl/squirmer_surface_velocity_defines.svh =====
// ----------------------------------------------------------------------------
// Squirmer surface velocity: assertion macros
// Short forms for the concurrent checks in the squirmer velocity pipeline.
// ----------------------------------------------------------------------------
`ifndef SQUIRMER_SURFACE_VELOCITY_DEFINES_SVH
`define SQUIRMER_SURFACE_VELOCITY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ssv_pkg.sv =====
// ----------------------------------------------------------------------------
// Squirmer surface velocity: package
// Register map, word layout and fixed sizes of the velocity pipeline.
// ----------------------------------------------------------------------------
package ssv_pkg;

	localparam int APB_AW     = 5;
	localparam int APB_DW     = 32;
	localparam int COMP_W     = 32;
	localparam int ITEM_W     = 96;
	localparam int USER_W     = 2;
	localparam int ROOT_STEPS = 32;
	localparam int DIV_STEPS  = 31;

	// Flag positions in the result tuser.
	localparam int USER_DEGEN = 0;
	localparam int USER_CLIP  = 1;

	typedef enum logic [2:0] {
		REG_ORIENT_W    = 3'd0,
		REG_ORIENT_X    = 3'd1,
		REG_ORIENT_Y    = 3'd2,
		REG_ORIENT_Z    = 3'd3,
		REG_SWIM_SPEED  = 3'd4,
		REG_DIPOLE_BETA = 3'd5
	} reg_idx_t;

	localparam logic [31:0] ORIENT_W_RST = 32'h4000_0000;
	localparam logic [31:0] VEL_MAX      = 32'h7FFF_FFFF;
	localparam logic [31:0] VEL_MIN      = 32'h8000_0000;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

endpackage

// ===== rtl/squirmer_surface_velocity.sv =====
// ----------------------------------------------------------------------------
// Squirmer surface velocity
// Slip velocity on a squirmer surface from a position relative to its centre.
// ----------------------------------------------------------------------------
// The block takes one position word per cycle and returns one velocity word per
// cycle, except while the pipeline halts. Every word passes through the
// square-root units (32 stages, one root bit per stage) and the unit-vector
// dividers (31 stages, one quotient bit per stage). The whole pipeline moves
// as one; it halts only while a finished word waits in the output register and
// the sink is not ready. The swimmer axis is worked out from the orientation
// registers for every word, so the registers must only be written while no word
// is in flight.
`include "squirmer_surface_velocity_defines.svh"

module squirmer_surface_velocity #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ssv_pkg::APB_AW-1:0]   paddr,
	input  logic [ssv_pkg::APB_DW-1:0]   pwdata,
	output logic [ssv_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// rel_x [31:0], rel_y [63:32], rel_z [95:64]
	input  logic [ssv_pkg::ITEM_W-1:0]   s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// vel_x [31:0], vel_y [63:32], vel_z [95:64]
	output logic [ssv_pkg::ITEM_W-1:0]   m_axis_tdata,
	// degenerate [0], clipped [1]
	output logic [ssv_pkg::USER_W-1:0]   m_axis_tuser
);
	import ssv_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [31:0] orient_w_q, orient_x_q, orient_y_q, orient_z_q;
	logic signed [31:0] speed_q, beta_q;
	reg_idx_t           reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_w_q <= ORIENT_W_RST;
			orient_x_q <= '0;
			orient_y_q <= '0;
			orient_z_q <= '0;
			speed_q    <= '0;
			beta_q     <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_ORIENT_W:    orient_w_q <= pwdata;
				REG_ORIENT_X:    orient_x_q <= pwdata;
				REG_ORIENT_Y:    orient_y_q <= pwdata;
				REG_ORIENT_Z:    orient_z_q <= pwdata;
				REG_SWIM_SPEED:  speed_q    <= pwdata;
				REG_DIPOLE_BETA: beta_q     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ORIENT_W:    prdata = orient_w_q;
			REG_ORIENT_X:    prdata = orient_x_q;
			REG_ORIENT_Y:    prdata = orient_y_q;
			REG_ORIENT_Z:    prdata = orient_z_q;
			REG_SWIM_SPEED:  prdata = speed_q;
			REG_DIPOLE_BETA: prdata = beta_q;
			default:         prdata = '0;
		endcase
	end

	// The pipeline moves whenever the output register is free or being taken.
	logic adv;
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// ------------------------------------------------------------------
	// Valid bits
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic vld_rt_s5 [ROOT_STEPS];
	logic vld_dv_s6 [DIV_STEPS];
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			for (int k = 0; k < ROOT_STEPS; k++) vld_rt_s5[k] <= 1'b0;
			for (int k = 0; k < DIV_STEPS; k++) vld_dv_s6[k] <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
		end else if (adv) begin
			vld_s1       <= s_axis_tvalid;
			vld_s2       <= vld_s1;
			vld_s3       <= vld_s2;
			vld_s4       <= vld_s3;
			vld_rt_s5[0] <= vld_s4;
			for (int k = 1; k < ROOT_STEPS; k++) vld_rt_s5[k] <= vld_rt_s5[k-1];
			vld_dv_s6[0] <= vld_rt_s5[ROOT_STEPS-1];
			for (int k = 1; k < DIV_STEPS; k++) vld_dv_s6[k] <= vld_dv_s6[k-1];
			vld_s7  <= vld_dv_s6[DIV_STEPS-1];
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
		end
	end

	// ------------------------------------------------------------------
	// Stages 1 to 4: rotated axis and squared lengths
	// ------------------------------------------------------------------
	logic signed [63:0] m_xz, m_wy, m_yz, m_wx, m_ww, m_xx, m_yy, m_zz;
	logic signed [31:0] rel_in [3];

	assign m_xz = orient_x_q * orient_z_q;
	assign m_wy = orient_w_q * orient_y_q;
	assign m_yz = orient_y_q * orient_z_q;
	assign m_wx = orient_w_q * orient_x_q;
	assign m_ww = orient_w_q * orient_w_q;
	assign m_xx = orient_x_q * orient_x_q;
	assign m_yy = orient_y_q * orient_y_q;
	assign m_zz = orient_z_q * orient_z_q;

	assign rel_in[0] = s_axis_tdata[31:0];
	assign rel_in[1] = s_axis_tdata[63:32];
	assign rel_in[2] = s_axis_tdata[95:64];

	logic signed [29:0] qxz_s1, qwy_s1, qyz_s1, qwx_s1, qww_s1, qxx_s1, qyy_s1, qzz_s1;
	logic [31:0] rmag_s1 [3];
	logic        rneg_s1 [3];
	logic [63:0] rsq_s1 [3];

	logic signed [31:0] ax_c [3];
	logic [31:0] amag_s2 [3];
	logic        aneg_s2 [3];
	logic [63:0] rsum_s2;
	logic [31:0] rmag_s2 [3];
	logic        rneg_s2 [3];

	logic [63:0] asq_s3 [3];
	logic [31:0] amag_s3 [3];
	logic        aneg_s3 [3];
	logic [63:0] rsum_s3;
	logic [31:0] rmag_s3 [3];
	logic        rneg_s3 [3];

	logic [63:0] asum_s4, rsum_s4;
	logic [31:0] amag_s4 [3];
	logic        aneg_s4 [3];
	logic [31:0] rmag_s4 [3];
	logic        rneg_s4 [3];

	// The products are taken with an arithmetic shift by 34; the x and y sums are then doubled.
	assign ax_c[0] = {31'(qxz_s1) + 31'(qwy_s1), 1'b0};
	assign ax_c[1] = {31'(qyz_s1) - 31'(qwx_s1), 1'b0};
	assign ax_c[2] = 32'(qww_s1) - 32'(qxx_s1) - 32'(qyy_s1) + 32'(qzz_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			qxz_s1 <= m_xz[63:34];
			qwy_s1 <= m_wy[63:34];
			qyz_s1 <= m_yz[63:34];
			qwx_s1 <= m_wx[63:34];
			qww_s1 <= m_ww[63:34];
			qxx_s1 <= m_xx[63:34];
			qyy_s1 <= m_yy[63:34];
			qzz_s1 <= m_zz[63:34];
			for (int i = 0; i < 3; i++) begin
				rmag_s1[i] <= mag32(rel_in[i]);
				rneg_s1[i] <= rel_in[i][31];
				rsq_s1[i]  <= 64'(mag32(rel_in[i])) * 64'(mag32(rel_in[i]));

				amag_s2[i] <= mag32(ax_c[i]);
				aneg_s2[i] <= ax_c[i][31];
				rmag_s2[i] <= rmag_s1[i];
				rneg_s2[i] <= rneg_s1[i];

				asq_s3[i]  <= 64'(amag_s2[i]) * 64'(amag_s2[i]);
				amag_s3[i] <= amag_s2[i];
				aneg_s3[i] <= aneg_s2[i];
				rmag_s3[i] <= rmag_s2[i];
				rneg_s3[i] <= rneg_s2[i];

				amag_s4[i] <= amag_s3[i];
				aneg_s4[i] <= aneg_s3[i];
				rmag_s4[i] <= rmag_s3[i];
				rneg_s4[i] <= rneg_s3[i];
			end
			rsum_s2 <= rsq_s1[0] + rsq_s1[1] + rsq_s1[2];
			rsum_s3 <= rsum_s2;
			asum_s4 <= asq_s3[0] + asq_s3[1] + asq_s3[2];
			rsum_s4 <= rsum_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage group 5: square roots, lane 0 for the axis, lane 1 for the
	// position, one root bit per stage
	// ------------------------------------------------------------------
	logic [63:0] rt_rad_s5  [ROOT_STEPS][2];
	logic [33:0] rt_rem_s5  [ROOT_STEPS][2];
	logic [31:0] rt_root_s5 [ROOT_STEPS][2];
	logic [63:0] rt_rad_in  [ROOT_STEPS][2];
	logic [33:0] rt_rem_in  [ROOT_STEPS][2];
	logic [31:0] rt_root_in [ROOT_STEPS][2];
	logic [63:0] rt_rad_nx  [ROOT_STEPS][2];
	logic [33:0] rt_rem_nx  [ROOT_STEPS][2];
	logic [31:0] rt_root_nx [ROOT_STEPS][2];
	logic [31:0] rt_amag_s5 [ROOT_STEPS][3];
	logic        rt_aneg_s5 [ROOT_STEPS][3];
	logic [31:0] rt_rmag_s5 [ROOT_STEPS][3];
	logic        rt_rneg_s5 [ROOT_STEPS][3];

	always_comb begin
		logic [35:0] sh;
		logic [35:0] trial;
		rt_rad_in[0][0]  = asum_s4;
		rt_rad_in[0][1]  = rsum_s4;
		rt_rem_in[0][0]  = '0;
		rt_rem_in[0][1]  = '0;
		rt_root_in[0][0] = '0;
		rt_root_in[0][1] = '0;
		for (int k = 1; k < ROOT_STEPS; k++) begin
			for (int l = 0; l < 2; l++) begin
				rt_rad_in[k][l]  = rt_rad_s5[k-1][l];
				rt_rem_in[k][l]  = rt_rem_s5[k-1][l];
				rt_root_in[k][l] = rt_root_s5[k-1][l];
			end
		end
		for (int k = 0; k < ROOT_STEPS; k++) begin
			for (int l = 0; l < 2; l++) begin
				sh    = {rt_rem_in[k][l], rt_rad_in[k][l][63:62]};
				trial = {2'b00, rt_root_in[k][l], 2'b01};
				if (sh >= trial) begin
					rt_rem_nx[k][l]  = 34'(sh - trial);
					rt_root_nx[k][l] = {rt_root_in[k][l][30:0], 1'b1};
				end else begin
					rt_rem_nx[k][l]  = sh[33:0];
					rt_root_nx[k][l] = {rt_root_in[k][l][30:0], 1'b0};
				end
				rt_rad_nx[k][l] = {rt_rad_in[k][l][61:0], 2'b00};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < ROOT_STEPS; k++) begin
				for (int l = 0; l < 2; l++) begin
					rt_rad_s5[k][l]  <= rt_rad_nx[k][l];
					rt_rem_s5[k][l]  <= rt_rem_nx[k][l];
					rt_root_s5[k][l] <= rt_root_nx[k][l];
				end
			end
			for (int i = 0; i < 3; i++) begin
				rt_amag_s5[0][i] <= amag_s4[i];
				rt_aneg_s5[0][i] <= aneg_s4[i];
				rt_rmag_s5[0][i] <= rmag_s4[i];
				rt_rneg_s5[0][i] <= rneg_s4[i];
			end
			for (int k = 1; k < ROOT_STEPS; k++) begin
				for (int i = 0; i < 3; i++) begin
					rt_amag_s5[k][i] <= rt_amag_s5[k-1][i];
					rt_aneg_s5[k][i] <= rt_aneg_s5[k-1][i];
					rt_rmag_s5[k][i] <= rt_rmag_s5[k-1][i];
					rt_rneg_s5[k][i] <= rt_rneg_s5[k-1][i];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage group 6: unit vectors, lanes 0-2 divide the axis by its length
	// and lanes 3-5 the position by its length, one quotient bit per stage
	// ------------------------------------------------------------------
	logic [32:0] dv_rem_s6 [DIV_STEPS][6];
	logic [30:0] dv_quo_s6 [DIV_STEPS][6];
	logic        dv_neg_s6 [DIV_STEPS][6];
	logic [31:0] dv_n_s6   [DIV_STEPS][2];
	logic        dv_degen_s6 [DIV_STEPS];
	logic [32:0] dv_rem_in [DIV_STEPS][6];
	logic [30:0] dv_quo_in [DIV_STEPS][6];
	logic [31:0] dv_n_in   [DIV_STEPS][2];
	logic [32:0] dv_rem_nx [DIV_STEPS][6];
	logic [30:0] dv_quo_nx [DIV_STEPS][6];
	logic [31:0] dv_num    [6];
	logic        dv_neg_in [6];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			dv_num[j]      = rt_amag_s5[ROOT_STEPS-1][j];
			dv_num[j+3]    = rt_rmag_s5[ROOT_STEPS-1][j];
			dv_neg_in[j]   = rt_aneg_s5[ROOT_STEPS-1][j];
			dv_neg_in[j+3] = rt_rneg_s5[ROOT_STEPS-1][j];
		end
	end

	always_comb begin
		logic [33:0] sh;
		logic [31:0] dvs;
		// Quotients stay below 2^31, so the top of the dividend starts as the
		// remainder and its lowest bit comes in at the first step.
		for (int j = 0; j < 6; j++) begin
			dv_rem_in[0][j] = 33'(dv_num[j][31:1]);
			dv_quo_in[0][j] = '0;
		end
		dv_n_in[0][0] = rt_root_s5[ROOT_STEPS-1][0];
		dv_n_in[0][1] = rt_root_s5[ROOT_STEPS-1][1];
		for (int k = 1; k < DIV_STEPS; k++) begin
			for (int j = 0; j < 6; j++) begin
				dv_rem_in[k][j] = dv_rem_s6[k-1][j];
				dv_quo_in[k][j] = dv_quo_s6[k-1][j];
			end
			dv_n_in[k][0] = dv_n_s6[k-1][0];
			dv_n_in[k][1] = dv_n_s6[k-1][1];
		end
		for (int k = 0; k < DIV_STEPS; k++) begin
			for (int j = 0; j < 6; j++) begin
				dvs = (j < 3) ? dv_n_in[k][0] : dv_n_in[k][1];
				sh  = {dv_rem_in[k][j], (k == 0) ? dv_num[j][0] : 1'b0};
				if (sh >= 34'(dvs)) begin
					dv_rem_nx[k][j] = 33'(sh - 34'(dvs));
					dv_quo_nx[k][j] = {dv_quo_in[k][j][29:0], 1'b1};
				end else begin
					dv_rem_nx[k][j] = sh[32:0];
					dv_quo_nx[k][j] = {dv_quo_in[k][j][29:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < DIV_STEPS; k++) begin
				for (int j = 0; j < 6; j++) begin
					dv_rem_s6[k][j] <= dv_rem_nx[k][j];
					dv_quo_s6[k][j] <= dv_quo_nx[k][j];
				end
				dv_n_s6[k][0] <= dv_n_in[k][0];
				dv_n_s6[k][1] <= dv_n_in[k][1];
			end
			for (int j = 0; j < 6; j++) dv_neg_s6[0][j] <= dv_neg_in[j];
			dv_degen_s6[0] <= (rt_root_s5[ROOT_STEPS-1][0] == '0) ||
				(rt_root_s5[ROOT_STEPS-1][1] == '0);
			for (int k = 1; k < DIV_STEPS; k++) begin
				for (int j = 0; j < 6; j++) dv_neg_s6[k][j] <= dv_neg_s6[k-1][j];
				dv_degen_s6[k] <= dv_degen_s6[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stages 7 to 15: cosine, dipole factor and scaling
	// ------------------------------------------------------------------
	logic signed [31:0] e_s7 [3], rs_s7 [3];
	logic               degen_s7;

	logic signed [63:0] dot_s8 [3];
	logic signed [31:0] e_s8 [3], rs_s8 [3];
	logic               degen_s8;

	logic signed [65:0] dot_sum_c;
	logic signed [33:0] c_s9;
	logic signed [31:0] e_s9 [3], rs_s9 [3];
	logic               degen_s9;

	logic signed [65:0] bc_s10;
	logic signed [65:0] crs_s10 [3];
	logic signed [31:0] e_s10 [3];
	logic               degen_s10;

	logic signed [33:0] g_c;
	logic signed [33:0] g_s11;
	logic signed [33:0] d_s11 [3];
	logic               degen_s11;

	logic signed [65:0] vg_s12;
	logic signed [33:0] d_s12 [3];
	logic               degen_s12;

	logic signed [65:0] t_c;
	logic signed [67:0] t3_c, s_c;
	logic [62:0]        sabs_s13;
	logic               sneg_s13;
	logic [32:0]        dabs_s13 [3];
	logic               dneg_s13 [3];
	logic               degen_s13;

	logic [63:0]        plo_s14 [3];
	logic [64:0]        phi_s14 [3];
	logic               neg_s14 [3];
	logic               degen_s14;

	logic [66:0]        prod_c [3];
	logic [31:0]        vel_c [3];
	logic               clip_c [3];
	logic [31:0]        vel_s15 [3];
	logic               degen_s15, clip_s15;

	assign dot_sum_c = 66'(dot_s8[0]) + 66'(dot_s8[1]) + 66'(dot_s8[2]);
	assign g_c       = 34'(bc_s10 >>> 30) + (34'(1) << FRAC_BITS);
	assign t_c       = vg_s12 >>> FRAC_BITS;
	assign t3_c      = 68'(t_c) + (68'(t_c) <<< 1);
	assign s_c       = t3_c >>> 1;

	// The speed factor is split at bit 31 so each half fits one multiplier;
	// the product shifted by 30 is then the high part doubled plus the low
	// part shifted.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod_c[i] = {1'b0, phi_s14[i], 1'b0} + 67'(plo_s14[i][63:30]);
			clip_c[i] = 1'b0;
			if (neg_s14[i]) begin
				if (prod_c[i] > 67'(VEL_MIN)) begin
					vel_c[i]  = VEL_MIN;
					clip_c[i] = 1'b1;
				end else begin
					vel_c[i] = 32'(-prod_c[i][31:0]);
				end
			end else begin
				if (prod_c[i] > 67'(VEL_MAX)) begin
					vel_c[i]  = VEL_MAX;
					clip_c[i] = 1'b1;
				end else begin
					vel_c[i] = prod_c[i][31:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				e_s7[i]  <= dv_neg_s6[DIV_STEPS-1][i] ?
					-$signed({1'b0, dv_quo_s6[DIV_STEPS-1][i]}) :
					$signed({1'b0, dv_quo_s6[DIV_STEPS-1][i]});
				rs_s7[i] <= dv_neg_s6[DIV_STEPS-1][i+3] ?
					-$signed({1'b0, dv_quo_s6[DIV_STEPS-1][i+3]}) :
					$signed({1'b0, dv_quo_s6[DIV_STEPS-1][i+3]});

				dot_s8[i] <= e_s7[i] * rs_s7[i];
				e_s8[i]   <= e_s7[i];
				rs_s8[i]  <= rs_s7[i];

				e_s9[i]  <= e_s8[i];
				rs_s9[i] <= rs_s8[i];

				crs_s10[i] <= c_s9 * rs_s9[i];
				e_s10[i]   <= e_s9[i];

				d_s11[i] <= 34'(crs_s10[i] >>> 30) - 34'(e_s10[i]);

				d_s12[i] <= d_s11[i];

				dabs_s13[i] <= d_s12[i][33] ? 33'(-d_s12[i]) : 33'(d_s12[i]);
				dneg_s13[i] <= d_s12[i][33];

				plo_s14[i] <= dabs_s13[i] * sabs_s13[30:0];
				phi_s14[i] <= dabs_s13[i] * sabs_s13[62:31];
				neg_s14[i] <= dneg_s13[i] ^ sneg_s13;

				vel_s15[i] <= degen_s14 ? '0 : vel_c[i];
			end
			degen_s7  <= dv_degen_s6[DIV_STEPS-1];
			degen_s8  <= degen_s7;
			c_s9      <= 34'(dot_sum_c >>> 30);
			degen_s9  <= degen_s8;
			bc_s10    <= beta_q * c_s9;
			degen_s10 <= degen_s9;
			g_s11     <= g_c;
			degen_s11 <= degen_s10;
			vg_s12    <= speed_q * g_s11;
			degen_s12 <= degen_s11;
			sabs_s13  <= s_c[67] ? 63'(-s_c) : 63'(s_c);
			sneg_s13  <= s_c[67];
			degen_s13 <= degen_s12;
			degen_s14 <= degen_s13;
			degen_s15 <= degen_s14;
			clip_s15  <= !degen_s14 && (clip_c[0] || clip_c[1] || clip_c[2]);
		end
	end

	assign m_axis_tvalid                = vld_s15;
	assign m_axis_tdata                 = {vel_s15[2], vel_s15[1], vel_s15[0]};
	assign m_axis_tuser[USER_DEGEN]     = degen_s15;
	assign m_axis_tuser[USER_CLIP]      = clip_s15;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`SSV_ASSERT_SAME(a_degen_zero, clk, arst_n,
		m_axis_tvalid && m_axis_tuser[USER_DEGEN],
		m_axis_tdata == '0 && !m_axis_tuser[USER_CLIP],
		"degenerate word carries a velocity or a clip flag")
	`SSV_ASSERT_SAME(a_clip_extreme, clk, arst_n,
		m_axis_tvalid && m_axis_tuser[USER_CLIP],
		m_axis_tdata[31:0] == VEL_MAX || m_axis_tdata[31:0] == VEL_MIN ||
		m_axis_tdata[63:32] == VEL_MAX || m_axis_tdata[63:32] == VEL_MIN ||
		m_axis_tdata[95:64] == VEL_MAX || m_axis_tdata[95:64] == VEL_MIN,
		"clip flag set without a saturated component")
	`SSV_ASSERT_SAME(a_stall_cause, clk, arst_n,
		!s_axis_tready,
		m_axis_tvalid && !m_axis_tready,
		"input held off without a waiting result")
	`SSV_ASSERT_NEXT(a_last_stage_moves, clk, arst_n,
		vld_s14 && adv,
		m_axis_tvalid,
		"word lost between the last stage and the output")

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Squirmer surface velocity testbench
// Streams positions through the slip velocity pipeline under several orientation,
// speed and dipole settings, predicts every velocity word in fixed point and
// checks each result word field by field, with random idling on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import ssv_pkg::*;

	localparam int  RAND_PER_PHASE = 300;
	localparam int  DRAIN_CYCLES   = 120;
	localparam longint CYCLE_LIMIT = 600000;

	typedef struct {
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [31:0] vel_z;
		logic        degen;
		logic        clip;
	} slip_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [ITEM_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [ITEM_W-1:0] m_axis_tdata;
	logic [USER_W-1:0] m_axis_tuser;

	// Shadow copy of the register file.
	logic signed [31:0] q_w = ORIENT_W_RST, q_x = '0, q_y = '0, q_z = '0;
	logic signed [31:0] speed_v0 = '0, beta_reg = '0;

	slip_t  pending_slip[$];
	int     fail_count = 0;
	int     words_sent = 0, words_checked = 0, config_writes = 0;
	longint cycle_count = 0;
	bit     idling_on = 1'b1;
	int     sink_hold = 0;

	squirmer_surface_velocity u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #2 clk = ~clk;

	function automatic logic [63:0] mag64(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] n);
		logic [63:0] r;
		logic [63:0] b;
		r = '0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint to_unit(longint a, logic [63:0] n);
		logic [63:0] q;
		q = (mag64(a) << 30) / n;
		return a < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [31:0] scale_clamp(longint d, longint s, ref logic clip);
		logic [127:0] m;
		m = (128'(mag64(d)) * 128'(mag64(s))) >> 30;
		if ((d < 0) != (s < 0)) begin
			if (m > 128'h8000_0000) begin
				clip = 1'b1;
				return VEL_MIN;
			end
			return 32'(-longint'(m[63:0]));
		end
		if (m > 128'h7FFF_FFFF) begin
			clip = 1'b1;
			return VEL_MAX;
		end
		return m[31:0];
	endfunction

	function automatic slip_t predict_slip(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz);
		longint w, x, y, z, c, g, t, s, d;
		longint ax[3], r[3], e[3], rs[3];
		logic [63:0] na, nr;
		logic clip;
		slip_t res;
		w = q_w; x = q_x; y = q_y; z = q_z;
		r[0] = px; r[1] = py; r[2] = pz;
		clip = 1'b0;
		res.vel_x = '0; res.vel_y = '0; res.vel_z = '0; res.degen = 1'b0;
		ax[0] = 2 * (((x * z) >>> 34) + ((w * y) >>> 34));
		ax[1] = 2 * (((y * z) >>> 34) - ((w * x) >>> 34));
		ax[2] = ((w * w) >>> 34) - ((x * x) >>> 34) - ((y * y) >>> 34) + ((z * z) >>> 34);
		na = int_sqrt(mag64(ax[0]) * mag64(ax[0]) + mag64(ax[1]) * mag64(ax[1])
			+ mag64(ax[2]) * mag64(ax[2]));
		nr = int_sqrt(mag64(r[0]) * mag64(r[0]) + mag64(r[1]) * mag64(r[1])
			+ mag64(r[2]) * mag64(r[2]));
		if (na == 0 || nr == 0) begin
			res.degen = 1'b1;
		end else begin
			for (int i = 0; i < 3; i++) begin
				e[i] = to_unit(ax[i], na);
				rs[i] = to_unit(r[i], nr);
			end
			c = (e[0] * rs[0] + e[1] * rs[1] + e[2] * rs[2]) >>> 30;
			g = (longint'(1) << 16) + ((longint'(beta_reg) * c) >>> 30);
			t = (longint'(speed_v0) * g) >>> 16;
			s = (3 * t) >>> 1;
			d = ((c * rs[0]) >>> 30) - e[0];
			res.vel_x = scale_clamp(d, s, clip);
			d = ((c * rs[1]) >>> 30) - e[1];
			res.vel_y = scale_clamp(d, s, clip);
			d = ((c * rs[2]) >>> 30) - e[2];
			res.vel_z = scale_clamp(d, s, clip);
		end
		res.clip = clip;
		return res;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH word %0d %s: got %h expected %h", words_checked, field, got, want);
		fail_count++;
	endtask

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_slip.size() == 0) begin
				$display("MISMATCH unexpected velocity word %h", m_axis_tdata);
				fail_count++;
			end else begin
				slip_t want;
				want = pending_slip.pop_front();
				if (m_axis_tdata[31:0] !== want.vel_x)
					report_mismatch("vel_x", m_axis_tdata[31:0], want.vel_x);
				if (m_axis_tdata[63:32] !== want.vel_y)
					report_mismatch("vel_y", m_axis_tdata[63:32], want.vel_y);
				if (m_axis_tdata[95:64] !== want.vel_z)
					report_mismatch("vel_z", m_axis_tdata[95:64], want.vel_z);
				if (m_axis_tuser[USER_DEGEN] !== want.degen)
					report_mismatch("degenerate", 32'(m_axis_tuser[USER_DEGEN]), 32'(want.degen));
				if (m_axis_tuser[USER_CLIP] !== want.clip)
					report_mismatch("clipped", 32'(m_axis_tuser[USER_CLIP]), 32'(want.clip));
			end
			words_checked++;
		end
	end

	// Sink stalls come in bursts.
	always @(posedge clk) begin
		if (!idling_on) begin
			m_axis_tready <= 1'b1;
		end else if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			sink_hold <= $urandom_range(0, 14);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_position(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {pz, py, px};
		do @(posedge clk); while (!s_axis_tready);
		pending_slip.push_back(predict_slip(px, py, pz));
		words_sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_slip.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= APB_AW'(4 * int'(idx)); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_ORIENT_W:    q_w = val;
			REG_ORIENT_X:    q_x = val;
			REG_ORIENT_Y:    q_y = val;
			REG_ORIENT_Z:    q_z = val;
			REG_SWIM_SPEED:  speed_v0 = val;
			REG_DIPOLE_BETA: beta_reg = val;
			default: ;
		endcase
		config_writes++;
	endtask

	task automatic set_swimmer(logic [31:0] w, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] v0, logic [31:0] beta);
		wait_drained();
		write_reg(REG_ORIENT_W, w);
		write_reg(REG_ORIENT_X, x);
		write_reg(REG_ORIENT_Y, y);
		write_reg(REG_ORIENT_Z, z);
		write_reg(REG_SWIM_SPEED, v0);
		write_reg(REG_DIPOLE_BETA, beta);
	endtask

	// With reset settings the speed is zero, so only the degenerate flag can show.
	task automatic test_reset_state();
		send_position(32'h0001_0000, 32'h0, 32'h0);
		send_position(32'h0, 32'h0, 32'h0);
		send_position(32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000);
	endtask

	task automatic test_directed();
		set_swimmer(32'h4000_0000, 0, 0, 0, 32'h0001_0000, 32'h0000_8000);
		send_position(32'h0, 32'h0, 32'h0);
		send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_position(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_position(32'h8000_0000, 32'h0, 32'h0);
		send_position(32'h0, 32'h7FFF_FFFF, 32'h0);
		send_position(32'h0, 32'h0, 32'h8000_0000);
		send_position(32'h0, 32'h0, 32'h0000_0001);
		send_position(32'h0000_0001, 32'hFFFF_FFFF, 32'h0);
		send_position(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		// An all-zero quaternion leaves no axis.
		set_swimmer(0, 0, 0, 0, 32'h0001_0000, 0);
		send_position(32'h0001_0000, 32'h0, 32'h0);
		send_position(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
		// Largest speed and dipole drive the velocity into saturation.
		set_swimmer(32'h2D41_3CCD, 32'h2D41_3CCD, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_position(32'h0001_0000, 32'h0, 32'h0);
		send_position(32'h0, 32'h0001_0000, 32'h0);
		send_position(32'h0, 32'h0001_0000, 32'h0001_0000);
		send_position(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		set_swimmer(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000);
		send_position(32'h0001_0000, 32'h0002_0000, 32'h0);
		send_position(32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
		send_position(32'h0, 32'hFFFF_0000, 32'h0001_0000);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
			2: return 32'($signed($urandom_range(0, 200)) - 100);
			3: return '0;
			4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom()) >>> $urandom_range(0, 31));
		endcase
	endfunction

	function automatic logic [31:0] rand_quat_part();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
			2: return '0;
			default: return 32'($signed($urandom()) >>> $urandom_range(0, 28));
		endcase
	endfunction

	task automatic test_random_phase(int phase);
		logic [31:0] v0;
		logic [31:0] beta;
		v0 = (phase % 3 == 0) ? $urandom() : 32'($signed($urandom()) >>> $urandom_range(8, 24));
		beta = (phase % 2 == 0) ? $urandom() : 32'($signed($urandom()) >>> $urandom_range(10, 24));
		set_swimmer(rand_quat_part(), rand_quat_part(), rand_quat_part(), rand_quat_part(),
			v0, beta);
		for (int i = 0; i < RAND_PER_PHASE; i++) begin
			if (phase == 1 && i == RAND_PER_PHASE / 2) begin
				// Hold the source back until every word in flight has come out.
				s_axis_tvalid <= 1'b0;
				while (pending_slip.size() != 0) @(posedge clk);
			end
			send_position(rand_coord(), rand_coord(), rand_coord());
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_state();
		test_directed();
		for (int p = 0; p < 6; p++) begin
			if (p == 5)
				idling_on = 1'b0;
			test_random_phase(p);
		end
		wait_drained();
		$display("Sent %0d position words, checked %0d velocity words, %0d register writes.",
			words_sent, words_checked, config_writes);
		$display("Covered zero positions, zero axis, saturation and random swimmer settings.");
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ssv_pkg.sv
rtl/squirmer_surface_velocity.sv
test/tb.sv
